// File: hw/rtl/capped_running_average_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the capped running average unit
// Both macros sample on aclk and are disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef CAPPED_RUNNING_AVERAGE_UNIT_ASSERT_SVH
`define CAPPED_RUNNING_AVERAGE_UNIT_ASSERT_SVH

// Same-cycle implication
`define CRA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define CRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/cra_pkg.sv
// ----------------------------------------------------------------------------
// cra_pkg
// Widths and constants shared by the capped running average unit.
// ----------------------------------------------------------------------------
package cra_pkg;

    localparam int SAMPLE_CAP = 255;      // samples before the average turns bounded
    localparam int IN_W       = 32;
    localparam int AVG_W      = 16;
    localparam int CNT_W      = 8;

    // Count test uses the cap clipped to the count range, and at least one
    localparam int EFF_CAP_INT = (SAMPLE_CAP > 255) ? 255 :
                                 ((SAMPLE_CAP < 1) ? 1 : SAMPLE_CAP);
    localparam logic [CNT_W-1:0] EFF_CAP = CNT_W'(EFF_CAP_INT);

    // Divider sizing: dividend holds avg*n+s, divisor holds up to cap+1
    localparam int NUM_W  = AVG_W + CNT_W;
    localparam int DEN_W  = 17;
    localparam int ITER_W = $clog2(NUM_W);
    localparam logic [DEN_W-1:0] CAP_DIVISOR = DEN_W'(SAMPLE_CAP + 1);

    localparam logic [AVG_W-1:0] SAMPLE_MAX = '1;

endpackage

// File: hw/rtl/capped_running_average_unit.sv
// ----------------------------------------------------------------------------
// capped_running_average_unit
// Running mean of duration samples with a bounded moving average at the cap.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one 32-bit sample per request. Zero is ignored, values
//   above 65535 saturate. Result channel m_*: one request per input request
//   with the average and sample count after that sample.
//   Sequencing: from input accept, ST_PREP leads straight to ST_FIN when no
//   division is needed (zero sample, first sample, unchanged average at the
//   cap), else through ST_DIV, the shared restoring divider, which retires
//   one quotient bit per cycle over a 24-bit dividend; ST_FIN sets m_valid.
//   One item at a time: s_ready is high only while the sequencer is idle,
//   so a new sample is taken only after the last one is committed.
//   The result sits in an output register, so the next input is taken while
//   a result waits; the sequencer then holds in its final step until the
//   receiver takes the pending result.
//   Reset (aresetn low, synchronous): average and count clear to zero, no
//   result pending, and the block is ready for input.
// ----------------------------------------------------------------------------
module capped_running_average_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [cra_pkg::IN_W-1:0]    s_sample_seconds,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [cra_pkg::AVG_W-1:0]   m_average_seconds,
    output logic [cra_pkg::CNT_W-1:0]   m_samples_counted
);
    import cra_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        MODE_KEEP,
        MODE_LOAD,
        MODE_MEAN,
        MODE_STEP
    } mode_t;

    state_t             state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic [AVG_W-1:0]   avg_reg, avg_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [AVG_W-1:0]   sample_reg, sample_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic               up_reg, up_next;
    logic               m_valid_reg, m_valid_next;
    logic [AVG_W-1:0]   m_avg_reg, m_avg_next;
    logic [CNT_W-1:0]   m_cnt_reg, m_cnt_next;

    logic [AVG_W-1:0]   sample_sat;
    logic [NUM_W-1:0]   mean_num;
    logic [DEN_W:0]     rem_shift;
    logic [DEN_W:0]     rem_diff;
    logic               quot_bit;
    logic [AVG_W-1:0]   quot;
    logic [AVG_W-1:0]   step;

    // Saturate the incoming sample to 16 bits
    assign sample_sat = (|s_sample_seconds[IN_W-1:AVG_W]) ? SAMPLE_MAX
                                                           : s_sample_seconds[AVG_W-1:0];

    // avg*n + s, fits the dividend since n stays below 255
    assign mean_num = NUM_W'(avg_reg) * NUM_W'(cnt_reg) + NUM_W'(sample_reg);

    // Restoring divider step: one quotient bit per cycle
    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign quot_bit  = (rem_shift >= {1'b0, den_reg});

    // Bounded step: at least one toward the sample
    assign quot = num_reg[AVG_W-1:0];
    assign step = (quot == '0) ? AVG_W'(1) : quot;

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_average_seconds = m_avg_reg;
    assign m_samples_counted = m_cnt_reg;

    // Sequencer next-state logic
    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        avg_next     = avg_reg;
        cnt_next     = cnt_reg;
        sample_next  = sample_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        iter_next    = iter_reg;
        up_next      = up_reg;
        m_valid_next = m_valid_reg;
        m_avg_next   = m_avg_reg;
        m_cnt_next   = m_cnt_reg;

        // Pending result taken by the receiver
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    sample_next = sample_sat;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP: begin
                rem_next  = '0;
                iter_next = '0;
                up_next   = (sample_reg > avg_reg);
                if (sample_reg == '0) begin
                    mode_next  = MODE_KEEP;
                    state_next = ST_FIN;
                end else if (cnt_reg == '0 || avg_reg == '0) begin
                    mode_next  = MODE_LOAD;
                    state_next = ST_FIN;
                end else if (cnt_reg < EFF_CAP) begin
                    mode_next  = MODE_MEAN;
                    num_next   = mean_num;
                    den_next   = DEN_W'(cnt_reg) + DEN_W'(1);
                    state_next = ST_DIV;
                end else if (sample_reg == avg_reg) begin
                    mode_next  = MODE_KEEP;
                    state_next = ST_FIN;
                end else begin
                    mode_next  = MODE_STEP;
                    num_next   = (sample_reg > avg_reg) ? NUM_W'(sample_reg - avg_reg)
                                                        : NUM_W'(avg_reg - sample_reg);
                    den_next   = CAP_DIVISOR;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next  = quot_bit ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
                num_next  = {num_reg[NUM_W-2:0], quot_bit};
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(NUM_W - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // Commit only once the output register is free
                if (!m_valid_reg || m_ready) begin
                    case (mode_reg)
                        MODE_LOAD: begin
                            avg_next = sample_reg;
                            cnt_next = CNT_W'(1);
                        end
                        MODE_MEAN: begin
                            avg_next = quot;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                        MODE_STEP: begin
                            avg_next = up_reg ? (avg_reg + step) : (avg_reg - step);
                        end
                        default: begin
                        end
                    endcase
                    m_avg_next   = avg_next;
                    m_cnt_next   = cnt_next;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            avg_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            avg_reg     <= avg_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        mode_reg   <= mode_next;
        sample_reg <= sample_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        iter_reg   <= iter_next;
        up_reg     <= up_next;
        m_avg_reg  <= m_avg_next;
        m_cnt_reg  <= m_cnt_next;
    end

`include "capped_running_average_unit_assert.svh"

    `CRA_ASSERT_IMPL(a_cnt_cap, 1'b1, cnt_reg <= EFF_CAP, "sample count above cap")
    `CRA_ASSERT_IMPL(a_empty_match, 1'b1, (cnt_reg == '0) == (avg_reg == '0), "avg/count mismatch")
    `CRA_ASSERT_NEXT(a_accept_prep, s_valid && s_ready, state_reg == ST_PREP, "accept not sequenced")
    `CRA_ASSERT_NEXT(a_div_done, (state_reg == ST_DIV) && (iter_reg == ITER_W'(NUM_W - 1)), state_reg == ST_FIN, "divider overrun")

endmodule

// File: bench/capped_running_average_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capped_running_average_checker
// Watches both channels of the capped running average unit. Each accepted
// sample is run through a local copy of the averaging rules. The predicted
// average and count are queued in request order. Each accepted result is
// compared field by field with the oldest queued prediction.
// ----------------------------------------------------------------------------
module capped_running_average_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [cra_pkg::IN_W-1:0]    s_sample_seconds,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [cra_pkg::AVG_W-1:0]   m_average_seconds,
    input  logic [cra_pkg::CNT_W-1:0]   m_samples_counted,
    output int                          failures,
    output int                          pending
);

    // The count register has 8 bits, so the count test clips the cap to 1..255
    localparam int COUNT_LIMIT = (cra_pkg::SAMPLE_CAP > 255) ? 255 :
                                 ((cra_pkg::SAMPLE_CAP < 1) ? 1 : cra_pkg::SAMPLE_CAP);
    // The bounded step still divides by the full cap plus one
    localparam int unsigned STEP_DIVISOR = cra_pkg::SAMPLE_CAP + 1;
    localparam int unsigned SAMPLE_CEIL  = 65535;

    typedef struct packed {
        logic [cra_pkg::AVG_W-1:0] average;
        logic [cra_pkg::CNT_W-1:0] count;
    } mean_result_t;

    logic [cra_pkg::AVG_W-1:0] mean_avg;
    logic [cra_pkg::CNT_W-1:0] mean_count;
    mean_result_t              mean_q[$];

    initial begin
        failures   = 0;
        pending    = 0;
        mean_avg   = '0;
        mean_count = '0;
    end

    // Fold one raw sample into the local mean and return the new state
    function automatic mean_result_t fold_sample(input logic [cra_pkg::IN_W-1:0] raw);
        int unsigned  s;
        int unsigned  avg;
        int unsigned  n;
        int unsigned  mag;
        int unsigned  step;
        mean_result_t res;
        if (raw != '0) begin
            s   = (raw > SAMPLE_CEIL) ? SAMPLE_CEIL : raw;
            avg = 32'(mean_avg);
            n   = 32'(mean_count);
            if (n == 0 || avg == 0) begin
                // empty mean, or nothing to average yet
                n          = 1;
                mean_avg   = s[cra_pkg::AVG_W-1:0];
                mean_count = n[cra_pkg::CNT_W-1:0];
            end else if (n < COUNT_LIMIT) begin
                // truncated cumulative mean
                avg        = (avg * n + s) / (n + 1);
                n          = n + 1;
                mean_avg   = avg[cra_pkg::AVG_W-1:0];
                mean_count = n[cra_pkg::CNT_W-1:0];
            end else if (s != avg) begin
                // at the cap: bounded step toward the sample, at least one
                mag  = (s > avg) ? s - avg : avg - s;
                step = mag / STEP_DIVISOR;
                if (step == 0)
                    step = 1;
                avg      = (s > avg) ? avg + step : avg - step;
                mean_avg = avg[cra_pkg::AVG_W-1:0];
            end
        end
        res.average = mean_avg;
        res.count   = mean_count;
        return res;
    endfunction

    always @(posedge aclk) begin
        mean_result_t want;
        if (!aresetn) begin
            mean_avg   = '0;
            mean_count = '0;
            mean_q.delete();
            pending    <= 0;
        end else begin
            // results first: a request accepted on this edge cannot answer yet
            if (m_valid && m_ready) begin
                if (mean_q.size() == 0) begin
                    $error("unexpected result: average_seconds %0d, samples_counted %0d",
                           m_average_seconds, m_samples_counted);
                    failures++;
                end else begin
                    want = mean_q.pop_front();
                    if (m_average_seconds !== want.average) begin
                        $error("average_seconds: expected %0d, actual %0d",
                               want.average, m_average_seconds);
                        failures++;
                    end
                    if (m_samples_counted !== want.count) begin
                        $error("samples_counted: expected %0d, actual %0d",
                               want.count, m_samples_counted);
                        failures++;
                    end
                end
            end
            if (s_valid && s_ready)
                mean_q.push_back(fold_sample(s_sample_seconds));
            pending <= mean_q.size();
        end
    end

endmodule

// File: bench/capped_running_average_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capped_running_average_unit_test
// Drives duration samples into the capped running average unit: a directed
// set of edge values, then random samples built mostly from runs of equal or
// nearby values so that the bounded average at the cap settles and stops.
// Four pacing phases vary sender gaps and receiver stalls. The checker
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module capped_running_average_unit_test;

    localparam int ITEMS_PER_PHASE = 200;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int DRAIN_CYCLES    = 64;

    typedef enum logic [1:0] {
        PACE_FULL,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } pace_t;

    logic                        aclk             = 1'b0;
    logic                        aresetn          = 1'b0;
    logic                        s_valid          = 1'b0;
    logic                        s_ready;
    logic [cra_pkg::IN_W-1:0]    s_sample_seconds = '0;
    logic                        m_valid;
    logic                        m_ready          = 1'b0;
    logic [cra_pkg::AVG_W-1:0]   m_average_seconds;
    logic [cra_pkg::CNT_W-1:0]   m_samples_counted;

    int    failures;
    int    pending;
    int    cycles   = 0;
    pace_t pace     = PACE_FULL;

    // random sample runs
    int          run_left  = 0;
    int unsigned run_value = 1000;

    always #2 aclk = ~aclk;

    capped_running_average_unit DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_sample_seconds  (s_sample_seconds),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_average_seconds (m_average_seconds),
        .m_samples_counted (m_samples_counted)
    );

    capped_running_average_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_sample_seconds  (s_sample_seconds),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_average_seconds (m_average_seconds),
        .m_samples_counted (m_samples_counted),
        .failures          (failures),
        .pending           (pending)
    );

    // Receiver stalls per pacing phase
    always @(posedge aclk) begin
        case (pace)
            PACE_RECV_STALL: m_ready <= ($urandom_range(99) >= 46);
            PACE_BOTH:       m_ready <= ($urandom_range(99) >= 34);
            default:         m_ready <= 1'b1;
        endcase
    end

    // Run guard
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("capped_running_average_unit test failed");
            $finish;
        end
    end

    // Offer one request, hold it until taken, then idle per the pacing phase
    task automatic send_sample(input logic [cra_pkg::IN_W-1:0] value);
        int gap;
        int idle_pct;
        s_valid          <= 1'b1;
        s_sample_seconds <= value;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        idle_pct = (pace == PACE_SEND_IDLE) ? 46 : (pace == PACE_BOTH) ? 34 : 0;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Mostly runs of one value, some drifting from the last run; the rest noise
    function automatic logic [cra_pkg::IN_W-1:0] pick_sample();
        int unsigned r;
        int          nudge;
        if (run_left > 0) begin
            run_left--;
            return run_value;
        end
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        if (r < 18)
            return $urandom();
        if (r < 24)
            return $urandom_range(16, 1);
        if (r < 30)
            return 32'h0001_0000 + $urandom_range(32'hFFFE_FFFF);
        if (r < 36)
            return 65535 - $urandom_range(15);
        if (r < 68) begin
            run_value = $urandom_range(65535, 1);
        end else begin
            nudge     = int'($urandom_range(6)) - 3;
            run_value = ((int'(run_value) + nudge) < 1) ? 1 :
                        ((int'(run_value) + nudge) > 65535) ? 65535 :
                        run_value + nudge;
        end
        run_left = $urandom_range(40, 3);
        return run_value;
    endfunction

    initial begin
        logic [cra_pkg::IN_W-1:0] edge_samples[$];
        edge_samples = '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd65535, 32'd65536,
                         32'h8000_0000, 32'd2, 32'd3, 32'h5555_5555, 32'hAAAA_AAAA,
                         32'd100, 32'd0, 32'h0000_FFFF, 32'd12345, 32'd1,
                         32'h0000_AAAA, 32'h0000_5555, 32'd65534, 32'd7};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed edge values
        foreach (edge_samples[i])
            send_sample(edge_samples[i]);

        // random samples through each pacing phase, then a closing full-rate burst
        for (int p = 0; p < 4; p++) begin
            pace <= pace_t'(p);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_sample(pick_sample());
        end
        pace <= PACE_FULL;
        for (int i = 0; i < 20; i++)
            send_sample(pick_sample());
        s_valid <= 1'b0;

        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (failures == 0)
            $display("capped_running_average_unit test passed");
        else
            $display("capped_running_average_unit test failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/cra_pkg.sv
hw/rtl/capped_running_average_unit.sv
bench/capped_running_average_checker.sv
bench/capped_running_average_unit_test.sv
